// ===== rtl/core/cpss_pkg.sv =====
// cpss_pkg: shared types, constants and pin tables of the charlieplex scroll scanner
// depends on nothing; used by cpss_ctrl, cpss_datapath and the top level
`default_nettype none

package cpss_pkg;

   // pattern store geometry (depth is a power of two, index wraps by truncation)
   localparam int PATTERN_DEPTH = 128;
   localparam int ADDR_W        = $clog2(PATTERN_DEPTH);
   localparam int BYTE_W        = 8;
   localparam int NIBBLE_W      = 4;

   // matrix geometry
   localparam int NUM_ROWS      = 5;
   localparam int NUM_COLS      = 4;
   localparam int NUM_PINS      = 5;
   localparam int SCAN_W        = 5;
   localparam logic [SCAN_W-1:0] SCAN_LAST = 5'd19;

   // field widths
   localparam int MODE_W   = 2;
   localparam int ADDRF_W  = 7;
   localparam int LEN_W    = 8;
   localparam int PERIOD_W = 16;
   localparam int POS_W    = 8;
   localparam int DVD_W    = POS_W - 1;

   // bus widths
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 16;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;

   // request modes
   localparam logic [MODE_W-1:0] MODE_TICK  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_WRITE = 2'd1;
   localparam logic [MODE_W-1:0] MODE_START = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_DATA_LEN      = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SCROLL_PERIOD = 1'd1;

   // reset values of the registers
   localparam logic [LEN_W-1:0]    DATA_LEN_RESET      = 8'd1;
   localparam logic [PERIOD_W-1:0] SCROLL_PERIOD_RESET = 16'd400;

   // bit-serial modulo step count and last row counter value
   localparam logic [2:0] DIV_LAST = 3'(DVD_W - 1);
   localparam logic [2:0] ROW_LAST = 3'(NUM_ROWS - 1);

   // anode and cathode pin of each led, indexed [row][col]
   localparam logic [2:0] ANODE_PIN [NUM_ROWS][NUM_COLS] = '{
      '{3'd2, 3'd0, 3'd1, 3'd0},
      '{3'd4, 3'd0, 3'd3, 3'd0},
      '{3'd3, 3'd1, 3'd2, 3'd1},
      '{3'd3, 3'd2, 3'd4, 3'd1},
      '{3'd4, 3'd3, 3'd4, 3'd2}
   };
   localparam logic [2:0] CATHODE_PIN [NUM_ROWS][NUM_COLS] = '{
      '{3'd0, 3'd2, 3'd0, 3'd1},
      '{3'd0, 3'd4, 3'd0, 3'd3},
      '{3'd1, 3'd3, 3'd1, 3'd2},
      '{3'd2, 3'd3, 3'd1, 3'd4},
      '{3'd3, 3'd4, 3'd2, 3'd4}
   };

   // one response, pin_dir in the low bits
   typedef struct packed {
      logic                lit;
      logic [NUM_PINS-1:0] pin_level;
      logic [NUM_PINS-1:0] pin_dir;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic take;
      logic latch;
      logic div_step;
      logic read;
      logic capture;
      logic post;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic need_latch;
      logic div_last;
      logic row_last;
      logic out_free;
   } status_type;

endpackage

`default_nettype wire

// ===== rtl/core/charlieplex_scroll_scanner_core.sv =====
// charlieplex_scroll_scanner_core: top level of the 4x5 charlieplex scroll scanner
// depends on cpss_pkg, cpss_ctrl, cpss_datapath (and cpss_ram below it)
//
// One request gives one response. A tick (mode 0) returns the pin direction and level
// of the next led of the scan, or all zero when that led is dark; a write (mode 1)
// stores a pattern byte, a start (mode 2) latches the first five rows, and both return
// all zero. A tick that does not scroll, a write and an unused mode go from accept
// straight to the response. A start, or a tick that scrolls, first runs the bit-serial
// modulo of the byte index by data_len, then the five pattern reads, each a read and
// a capture on the single read port of the pattern ram. The next request is taken
// once the response is in the output register; a waiting response does not hold up
// the next request, only the posting of its result. Configuration is to be written
// by the user only while the block is idle; the block itself does not enforce this.
`default_nettype none

module charlieplex_scroll_scanner_core (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // request: tdata = address [6:0], data [14:7], zero [15]
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   input  wire logic [cpss_pkg::REQ_DATA_W-1:0]     req_tdata,
   // request: tuser = mode [1:0]
   input  wire logic [cpss_pkg::MODE_W-1:0]         req_tuser,
   // response: tdata = pin_dir [4:0], pin_level [9:5], lit [10], zero [15:11]
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   output logic      [cpss_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // configuration write port
   input  wire logic                                csr_we,
   input  wire logic [cpss_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [cpss_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   cpss_pkg::cmd_type    cmd;
   cpss_pkg::status_type status;
   cpss_pkg::rsp_type    rsp_payload;

   // sequencer
   cpss_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .status    (status),
      .cmd       (cmd)
   );

   // scan state, row latch and response register
   cpss_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_mode   (req_tuser),
      .req_address(req_tdata[6:0]),
      .req_data   (req_tdata[14:7]),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .rsp_tready (rsp_tready),
      .rsp_valid  (rsp_tvalid),
      .rsp_payload(rsp_payload)
   );

   // pack the response, zero fill to whole bytes
   assign rsp_tdata = {(cpss_pkg::RSP_DATA_W - $bits(cpss_pkg::rsp_type))'(0), rsp_payload};

endmodule

`default_nettype wire

// ===== rtl/core/cpss_ram.sv =====
// cpss_ram: generic single-clock ram, one write port and one registered read port
// depends on nothing
`default_nettype none

module cpss_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/cpss_ctrl.sv =====
// cpss_ctrl: sequencer of the scanner: request intake, row latch steps, response post
// depends on cpss_pkg
`default_nettype none

module cpss_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire cpss_pkg::status_type  status,
   output cpss_pkg::cmd_type          cmd
);

   typedef enum logic [2:0] {
      IDLE,
      DIV,
      READ,
      CAPTURE,
      POST
   } state_type;

   state_type state_ff, state_in;
   logic      ready_ff, ready_in;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         IDLE: begin
            cmd.take = req_tvalid && ready_ff;
            if (req_tvalid && ready_ff) begin
               cmd.latch = status.need_latch;
               state_in  = status.need_latch ? DIV : POST;
            end
         end
         DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = READ;
            end
         end
         READ: begin
            cmd.read = 1'b1;
            state_in = CAPTURE;
         end
         CAPTURE: begin
            cmd.capture = 1'b1;
            state_in    = status.row_last ? POST : READ;
         end
         POST: begin
            cmd.post = status.out_free;
            if (status.out_free) begin
               state_in = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
      ready_in = (state_in == IDLE);
   end

   // state and registered ready, ready stays low in reset
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         ready_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ready_ff <= ready_in;
      end
   end

   assign req_tready = ready_ff;

   // ready only in the idle state
   assert property (@(posedge clock) disable iff (reset)
      ready_ff |-> state_ff == IDLE)
      else $error("ready out of step with idle state");

   // a request is taken only with ready high
   assert property (@(posedge clock) disable iff (reset)
      cmd.take |-> ready_ff)
      else $error("request taken without ready");

   // a ram read is always followed by its capture
   assert property (@(posedge clock) disable iff (reset)
      state_ff == READ |=> state_ff == CAPTURE)
      else $error("read not followed by capture");

endmodule

`default_nettype wire

// ===== rtl/core/cpss_datapath.sv =====
// cpss_datapath: scan state, row latch (bit-serial modulo, pattern reads), response register
// depends on cpss_pkg and cpss_ram
`default_nettype none

module cpss_datapath (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire cpss_pkg::cmd_type                   cmd,
   output cpss_pkg::status_type                     status,
   input  wire logic [cpss_pkg::MODE_W-1:0]         req_mode,
   input  wire logic [cpss_pkg::ADDRF_W-1:0]        req_address,
   input  wire logic [cpss_pkg::BYTE_W-1:0]         req_data,
   input  wire logic                                csr_we,
   input  wire logic [cpss_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [cpss_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  wire logic                                rsp_tready,
   output logic                                     rsp_valid,
   output cpss_pkg::rsp_type                        rsp_payload
);

   logic [cpss_pkg::NIBBLE_W-1:0] rows_ff [cpss_pkg::NUM_ROWS];
   logic [cpss_pkg::NIBBLE_W-1:0] rows_in [cpss_pkg::NUM_ROWS];
   logic [cpss_pkg::POS_W-1:0]    scroll_pos_ff, scroll_pos_in;
   logic [cpss_pkg::SCAN_W-1:0]   scan_ff, scan_in;
   logic [cpss_pkg::PERIOD_W-1:0] ticks_ff, ticks_in;
   logic [cpss_pkg::LEN_W-1:0]    data_len_ff, data_len_in;
   logic [cpss_pkg::PERIOD_W-1:0] period_ff, period_in;
   logic [cpss_pkg::LEN_W-1:0]    rem_ff, rem_in;
   logic [cpss_pkg::DVD_W-1:0]    dvd_ff, dvd_in;
   logic [2:0]                    div_cnt_ff, div_cnt_in;
   logic [cpss_pkg::LEN_W-1:0]    idx_ff, idx_in;
   logic [2:0]                    row_cnt_ff, row_cnt_in;
   cpss_pkg::rsp_type             res_ff, res_in;
   cpss_pkg::rsp_type             rsp_ff, rsp_in;
   logic                          rsp_valid_ff, rsp_valid_in;

   logic [cpss_pkg::LEN_W-1:0]    len_eff;
   logic [cpss_pkg::PERIOD_W-1:0] ticks_next;
   logic                          scroll_due;
   logic [cpss_pkg::SCAN_W-1:0]   sp_eff;
   logic [1:0]                    col;
   logic [2:0]                    row;
   logic                          led_on;
   logic [2:0]                    anode, cathode;
   logic [cpss_pkg::LEN_W:0]      trial;
   logic [cpss_pkg::LEN_W:0]      idx_inc;
   logic [cpss_pkg::LEN_W-1:0]    rem_next;
   logic                          nib_odd;
   logic [cpss_pkg::BYTE_W-1:0]   rd_data;
   logic                          wr_en;

   // pattern store
   cpss_ram #(
      .WIDTH(cpss_pkg::BYTE_W),
      .DEPTH(cpss_pkg::PATTERN_DEPTH)
   ) u_pattern (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(req_address[cpss_pkg::ADDR_W-1:0]),
      .wr_data(req_data),
      .rd_en  (cmd.read),
      .rd_addr(idx_ff[cpss_pkg::ADDR_W-1:0]),
      .rd_data(rd_data)
   );

   assign wr_en = cmd.take && (req_mode == cpss_pkg::MODE_WRITE)
                  && (32'(req_address) < cpss_pkg::PATTERN_DEPTH);

   // zero length counts as one byte
   assign len_eff = (data_len_ff == '0) ? cpss_pkg::LEN_W'(1) : data_len_ff;

   // tick bookkeeping and led lookup
   always_comb begin
      ticks_next = ticks_ff + cpss_pkg::PERIOD_W'(1);
      scroll_due = ticks_next > period_ff;
      sp_eff     = (scan_ff > cpss_pkg::SCAN_LAST) ? '0 : scan_ff;
      col        = sp_eff[1:0];
      row        = sp_eff[4:2];
      anode      = '0;
      cathode    = '0;
      led_on     = 1'b0;
      if (32'(row) < cpss_pkg::NUM_ROWS) begin
         led_on  = rows_ff[row][col];
         anode   = cpss_pkg::ANODE_PIN[row][col];
         cathode = cpss_pkg::CATHODE_PIN[row][col];
      end
   end

   // one restoring step of the byte index modulo
   always_comb begin
      trial    = {rem_ff, dvd_ff[cpss_pkg::DVD_W-1]};
      rem_next = (trial >= {1'b0, len_eff}) ? cpss_pkg::LEN_W'(trial - {1'b0, len_eff})
                                            : trial[cpss_pkg::LEN_W-1:0];
      idx_inc  = {1'b0, idx_ff} + 1'b1;
      nib_odd  = scroll_pos_ff[0] ^ row_cnt_ff[0];
   end

   assign status.need_latch = (req_mode == cpss_pkg::MODE_START)
                              || ((req_mode == cpss_pkg::MODE_TICK) && scroll_due);
   assign status.div_last   = (div_cnt_ff == cpss_pkg::DIV_LAST);
   assign status.row_last   = (row_cnt_ff == cpss_pkg::ROW_LAST);
   assign status.out_free   = !rsp_valid_ff || rsp_tready;

   // next state of the datapath registers
   always_comb begin
      rows_in       = rows_ff;
      scroll_pos_in = scroll_pos_ff;
      scan_in       = scan_ff;
      ticks_in      = ticks_ff;
      data_len_in   = data_len_ff;
      period_in     = period_ff;
      rem_in        = rem_ff;
      dvd_in        = dvd_ff;
      div_cnt_in    = div_cnt_ff;
      idx_in        = idx_ff;
      row_cnt_in    = row_cnt_ff;
      res_in        = res_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff;

      // register writes
      if (csr_we) begin
         case (csr_index)
            cpss_pkg::CSR_DATA_LEN:      data_len_in = csr_wdata[cpss_pkg::LEN_W-1:0];
            cpss_pkg::CSR_SCROLL_PERIOD: period_in   = csr_wdata;
            default: ;
         endcase
      end

      // request intake
      if (cmd.take) begin
         res_in = '0;
         case (req_mode)
            cpss_pkg::MODE_TICK: begin
               if (led_on) begin
                  res_in.pin_dir   = (cpss_pkg::NUM_PINS'(1) << anode)
                                     | (cpss_pkg::NUM_PINS'(1) << cathode);
                  res_in.pin_level = cpss_pkg::NUM_PINS'(1) << anode;
                  res_in.lit       = 1'b1;
               end
               scan_in  = (sp_eff == cpss_pkg::SCAN_LAST) ? '0
                          : sp_eff + cpss_pkg::SCAN_W'(1);
               ticks_in = scroll_due ? '0 : ticks_next;
            end
            cpss_pkg::MODE_START: begin
               scroll_pos_in = '0;
               ticks_in      = '0;
            end
            default: ;
         endcase
         // start the modulo from the position the latch will use
         if (cmd.latch) begin
            rem_in     = '0;
            div_cnt_in = '0;
            dvd_in     = (req_mode == cpss_pkg::MODE_START) ? '0
                         : scroll_pos_ff[cpss_pkg::POS_W-1:1];
         end
      end

      // bit-serial modulo of the byte index
      if (cmd.div_step) begin
         rem_in     = rem_next;
         dvd_in     = {dvd_ff[cpss_pkg::DVD_W-2:0], 1'b0};
         div_cnt_in = div_cnt_ff + 3'd1;
         if (status.div_last) begin
            idx_in     = rem_next;
            row_cnt_in = '0;
         end
      end

      // capture one row nibble, step to the next byte after a low nibble
      if (cmd.capture) begin
         if (32'(row_cnt_ff) < cpss_pkg::NUM_ROWS) begin
            rows_in[row_cnt_ff] = nib_odd ? rd_data[3:0] : rd_data[7:4];
         end
         if (nib_odd) begin
            idx_in = (idx_inc == {1'b0, len_eff}) ? '0 : idx_inc[cpss_pkg::LEN_W-1:0];
         end
         row_cnt_in = row_cnt_ff + 3'd1;
         if (status.row_last) begin
            scroll_pos_in = scroll_pos_ff + cpss_pkg::POS_W'(1);
         end
      end

      // response register
      if (cmd.post) begin
         rsp_in       = res_ff;
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < cpss_pkg::NUM_ROWS; i++) begin
            rows_ff[i] <= '0;
         end
         scroll_pos_ff <= '0;
         scan_ff       <= '0;
         ticks_ff      <= '0;
         data_len_ff   <= cpss_pkg::DATA_LEN_RESET;
         period_ff     <= cpss_pkg::SCROLL_PERIOD_RESET;
         div_cnt_ff    <= '0;
         row_cnt_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rows_ff       <= rows_in;
         scroll_pos_ff <= scroll_pos_in;
         scan_ff       <= scan_in;
         ticks_ff      <= ticks_in;
         data_len_ff   <= data_len_in;
         period_ff     <= period_in;
         div_cnt_ff    <= div_cnt_in;
         row_cnt_ff    <= row_cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      idx_ff <= idx_in;
      res_ff <= res_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // scan position never leaves the matrix
   assert property (@(posedge clock) disable iff (reset)
      scan_ff <= cpss_pkg::SCAN_LAST)
      else $error("scan position out of range");

   // byte index stays below the pattern length while reading
   assert property (@(posedge clock) disable iff (reset)
      cmd.read |-> ({1'b0, idx_ff} < {1'b0, len_eff}))
      else $error("byte index not reduced");

   // the last row capture advances the scroll position by one
   assert property (@(posedge clock) disable iff (reset)
      cmd.capture && status.row_last
      |=> scroll_pos_ff == $past(scroll_pos_ff) + cpss_pkg::POS_W'(1))
      else $error("scroll position not advanced after latch");

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
// testbench: self-checking bench of charlieplex_scroll_scanner_core
// depends on cpss_pkg and the core; predicts every pin drive in a small scoreboard class
`default_nettype none

module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [cpss_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;
   localparam int STORE_DEPTH = 128;
   localparam logic [4:0] SCAN_WRAP = 5'd19;
   localparam int SETTLE_CYCLES = 24;

   // anode and cathode pin of each led, [row][col]
   localparam int LED_ANODE [5][4] = '{
      '{2, 0, 1, 0}, '{4, 0, 3, 0}, '{3, 1, 2, 1}, '{3, 2, 4, 1}, '{4, 3, 4, 2}
   };
   localparam int LED_CATHODE [5][4] = '{
      '{0, 2, 0, 1}, '{0, 4, 0, 3}, '{1, 3, 1, 2}, '{2, 3, 1, 4}, '{3, 4, 2, 4}
   };

   // tracks the scanner state and holds the pin drives still to come
   class drive_tracker;
      logic [7:0]  pattern [STORE_DEPTH];
      logic [3:0]  rows [5];
      logic [7:0]  scroll_pos;
      logic [4:0]  scan_pos;
      logic [15:0] tick_count;
      logic [7:0]  data_len;
      logic [15:0] scroll_period;
      cpss_pkg::rsp_type pending_drives [$];
      int errors;

      function new();
         foreach (pattern[i]) pattern[i] = 8'h00;
         foreach (rows[i]) rows[i] = 4'h0;
         scroll_pos    = 8'd0;
         scan_pos      = 5'd0;
         tick_count    = 16'd0;
         data_len      = 8'd1;
         scroll_period = 16'd400;
         errors        = 0;
      endfunction

      function void set_register(logic [cpss_pkg::CSR_IDX_W-1:0] index, logic [15:0] value);
         if (index == cpss_pkg::CSR_DATA_LEN)
            data_len = value[7:0];
         else
            scroll_period = value;
      endfunction

      // five rows from the nibbles at the scroll position, then step the position
      function void latch_rows();
         int len;
         int n;
         int idx;
         logic [7:0] b;
         len = (data_len == 8'd0) ? 1 : int'(data_len);
         for (int r = 0; r < 5; r++) begin
            n   = int'(scroll_pos) + r;
            idx = ((n / 2) % len) % STORE_DEPTH;
            b   = pattern[idx];
            rows[r] = (n % 2 == 1) ? b[3:0] : b[7:4];
         end
         scroll_pos = scroll_pos + 8'd1;
      endfunction

      function void note_request(logic [1:0] mode, logic [6:0] address, logic [7:0] data);
         cpss_pkg::rsp_type drive;
         int col;
         int row;
         int a;
         int c;
         drive = '0;
         case (mode)
            cpss_pkg::MODE_TICK: begin
               col = int'(scan_pos) % 4;
               row = int'(scan_pos) / 4;
               tick_count = tick_count + 16'd1;
               if (rows[row][col]) begin
                  a = LED_ANODE[row][col];
                  c = LED_CATHODE[row][col];
                  drive.pin_dir   = 5'(1 << a) | 5'(1 << c);
                  drive.pin_level = 5'(1 << a);
                  drive.lit       = 1'b1;
               end
               scan_pos = (scan_pos >= SCAN_WRAP) ? 5'd0 : scan_pos + 5'd1;
               if (tick_count > scroll_period) begin
                  tick_count = 16'd0;
                  latch_rows();
               end
            end
            cpss_pkg::MODE_WRITE: pattern[address] = data;
            cpss_pkg::MODE_START: begin
               scroll_pos = 8'd0;
               latch_rows();
               tick_count = 16'd0;
            end
            default: ;
         endcase
         pending_drives.push_back(drive);
      endfunction

      task report(string msg);
         if (errors < 100)
            $display("mismatch: %s", msg);
         errors++;
      endtask

      task check_response(logic [15:0] tdata);
         cpss_pkg::rsp_type got;
         cpss_pkg::rsp_type want;
         got = tdata[10:0];
         if (pending_drives.size() == 0) begin
            report($sformatf("response %h with nothing pending", tdata));
            return;
         end
         want = pending_drives.pop_front();
         if (got.pin_dir != want.pin_dir)
            report($sformatf("pin_dir %h, want %h", got.pin_dir, want.pin_dir));
         if (got.pin_level != want.pin_level)
            report($sformatf("pin_level %h, want %h", got.pin_level, want.pin_level));
         if (got.lit != want.lit)
            report($sformatf("lit %b, want %b", got.lit, want.lit));
      endtask
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [cpss_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   logic [cpss_pkg::MODE_W-1:0] req_tuser = cpss_pkg::MODE_TICK;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [cpss_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic csr_we = 1'b0;
   logic [cpss_pkg::CSR_IDX_W-1:0] csr_index = cpss_pkg::CSR_DATA_LEN;
   logic [cpss_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   drive_tracker tracker = new();
   bit sender_burst = 1'b0;
   bit receiver_burst = 1'b0;

   charlieplex_scroll_scanner_core uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #4 clock = ~clock;

   // one request: optional gap, then hold valid until accepted
   task send_request(logic [1:0] mode, logic [6:0] address, logic [7:0] data);
      int gap;
      gap = sender_burst ? 0 : $urandom_range(0, 18);
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= {1'b0, data, address};
      do @(posedge clock); while (!req_tready);
      tracker.note_request(mode, address, data);
   endtask

   task write_register(logic [cpss_pkg::CSR_IDX_W-1:0] index, logic [15:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
      tracker.set_register(index, value);
   endtask

   // stop requesting and let every pending drive come out
   task wait_for_drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (tracker.pending_drives.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // response side: random stalls, check at each accept
   initial begin
      int stall;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         stall = receiver_burst ? 0 : $urandom_range(0, 18);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         tracker.check_response(rsp_tdata);
         @(negedge clock);
      end
   end

   // stimulus
   initial begin
      int phase_len [10];
      int phase_period [10];
      int order [STORE_DEPTH];
      int pick;
      int tmp;
      int len;
      int period;
      int roll;
      logic [1:0] mode;

      phase_len    = '{128, 0, 255, 1, -1, 128, -1, 2, -1, 128};
      phase_period = '{7, 0, 1, 2, -1, 65535, -1, 3, -1, 1};

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: dark tick before start, unused mode, field extremes, full lit frame
      send_request(cpss_pkg::MODE_TICK, 7'd0, 8'h00);
      send_request(MODE_UNUSED, 7'd127, 8'hFF);
      send_request(cpss_pkg::MODE_WRITE, 7'd0, 8'hFF);
      send_request(cpss_pkg::MODE_WRITE, 7'd127, 8'h00);
      send_request(cpss_pkg::MODE_START, 7'd127, 8'hFF);
      for (int i = 0; i < 20; i++)
         send_request(cpss_pkg::MODE_TICK, 7'($urandom), 8'($urandom));

      // fill the whole pattern store in shuffled order so no read finds an empty byte
      foreach (order[i]) order[i] = i;
      for (int i = STORE_DEPTH - 1; i > 0; i--) begin
         pick = $urandom_range(0, i);
         tmp = order[i];
         order[i] = order[pick];
         order[pick] = tmp;
      end
      for (int i = 0; i < STORE_DEPTH; i++) begin
         if (i % 32 == 0) begin
            sender_burst   = ($urandom_range(0, 2) == 0);
            receiver_burst = ($urandom_range(0, 2) == 0);
         end
         send_request(cpss_pkg::MODE_WRITE, 7'(order[i]), 8'($urandom));
      end

      // random phases, each with its own register setting
      for (int p = 0; p < 10; p++) begin
         wait_for_drain();
         len    = (phase_len[p] < 0) ? $urandom_range(1, 128) : phase_len[p];
         period = (phase_period[p] < 0) ? $urandom_range(0, 30) : phase_period[p];
         write_register(cpss_pkg::CSR_DATA_LEN, {8'($urandom), 8'(len)});
         write_register(cpss_pkg::CSR_SCROLL_PERIOD, 16'(period));
         for (int i = 0; i < 140; i++) begin
            if (i % 40 == 0) begin
               sender_burst   = ($urandom_range(0, 3) == 0);
               receiver_burst = ($urandom_range(0, 3) == 0);
            end
            roll = $urandom_range(0, 99);
            if (roll < 78)
               mode = cpss_pkg::MODE_TICK;
            else if (roll < 88)
               mode = cpss_pkg::MODE_WRITE;
            else if (roll < 95)
               mode = cpss_pkg::MODE_START;
            else
               mode = MODE_UNUSED;
            send_request(mode, 7'($urandom), 8'($urandom));
         end
      end

      // final drain and verdict
      wait_for_drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (tracker.pending_drives.size() != 0)
         tracker.report($sformatf("%0d drives never came", tracker.pending_drives.size()));
      if (tracker.errors == 0)
         $display("testbench passed");
      else
         $display("testbench failed");
      $finish;
   end

   // hard stop far beyond the slowest legal run
   initial begin
      #5_000_000;
      $display("testbench failed");
      $finish;
   end

endmodule

`default_nettype wire
